// ----- sv/rahm_pkg.sv -----
// ----------------------------------------------------------------------------
// rahm_pkg
// Shared types, constants and the log2 fraction table of the anchor health
// monitor.
// ----------------------------------------------------------------------------
package rahm_pkg;

  // Fraction table of the fixed-point log2.
  localparam int unsigned LOG_TABLE_BITS = 6;
  localparam int unsigned LOG_ENTRIES    = 1 << LOG_TABLE_BITS;
  localparam int unsigned LOG_ROM_DEPTH  = LOG_ENTRIES + 1;
  localparam int unsigned LOG_IDX_W      = $clog2(LOG_ROM_DEPTH);
  localparam int unsigned LOG_FRAC_BITS  = 16;
  localparam int unsigned LOG_ENTRY_W    = LOG_FRAC_BITS + 1;
  localparam int unsigned INTERP_BITS    = 8;

  // Distances are normalized in a register of this width.
  localparam int unsigned NORM_W = 20;
  localparam int unsigned EXP_W  = $clog2(NORM_W);
  localparam int unsigned LOG_W  = EXP_W + LOG_FRAC_BITS;

  // Bit-serial multiplier: multiplicand width, multiplier width, product.
  localparam int unsigned MUL_AW    = 32;
  localparam int unsigned MUL_BW    = 18;
  localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_BW + 1);

  // 10 * log10(2) in Q.16.
  localparam logic [MUL_BW-1:0] TEN_LOG10_2_Q16 = 18'd197283;

  localparam logic [16:0] LAMBDA_ONE  = 17'd65536;
  localparam logic [23:0] WARN_LEVEL  = 24'd1024;
  localparam logic [23:0] FAULT_LEVEL = 24'd2048;
  localparam logic [23:0] AVG_MAX     = 24'hFF_FFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA    = 2'd0,
    CFG_REF_DIST  = 2'd1,
    CFG_INV_SIGMA = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_PREP,
    ST_MUL_NL,
    ST_MUL_K,
    ST_RESID,
    ST_MUL_SIG,
    ST_SQUARE,
    ST_MUL_ZZ,
    ST_MUL_LQ,
    ST_MUL_LA,
    ST_FINISH
  } rahm_state_e;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  // Entry i holds log2(1 + i / LOG_ENTRIES) in Q.16, truncated, found by
  // repeated squaring. The last entry is exactly one.
  function automatic logic [LOG_ROM_DEPTH-1:0][LOG_ENTRY_W-1:0] build_log_rom();
    logic [LOG_ROM_DEPTH-1:0][LOG_ENTRY_W-1:0] rom;
    logic [63:0]                               m;
    logic [LOG_FRAC_BITS-1:0]                  acc;
    rom = '0;
    for (int i = 0; i < int'(LOG_ROM_DEPTH); i++) begin
      if (i == int'(LOG_ENTRIES)) begin
        rom[i] = LOG_ENTRY_W'(1 << LOG_FRAC_BITS);
      end else begin
        m   = 64'(int'(LOG_ENTRIES) + i) << (30 - LOG_TABLE_BITS);
        acc = '0;
        for (int b = int'(LOG_FRAC_BITS) - 1; b >= 0; b--) begin
          m = (m * m) >> 30;
          if (m >= 64'h0000_0000_8000_0000) begin
            acc[b] = 1'b1;
            m      = m >> 1;
          end
        end
        rom[i] = {1'b0, acc};
      end
    end
    return rom;
  endfunction

  localparam logic [LOG_ROM_DEPTH-1:0][LOG_ENTRY_W-1:0] LOG_ROM = build_log_rom();

endpackage

// ----- sv/rahm_serial_mul.sv -----
// ----------------------------------------------------------------------------
// rahm_serial_mul
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rahm_serial_mul import rahm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mul_req_t          req_i,
  output logic              done_o,
  output logic [MUL_PW-1:0] product_o
);

  logic [MUL_AW-1:0]    a_q;
  logic [MUL_PW-1:0]    p_q;
  logic [MUL_PW-1:0]    p_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [MUL_AW-1:0]    addend;
  logic [MUL_AW:0]      upper_sum;

  // The multiplier sits in the low bits and drains out at bit zero while the
  // partial product grows in from the top.
  always_comb begin
    addend    = p_q[0] ? a_q : '0;
    upper_sum = {1'b0, p_q[MUL_PW-1:MUL_BW]} + {1'b0, addend};
    p_d       = {upper_sum, p_q[MUL_BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CNT_W'(MUL_BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - MUL_CNT_W'(1);
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{MUL_AW{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = p_q;

endmodule

// ----- sv/rahm_log2.sv -----
// ----------------------------------------------------------------------------
// rahm_log2
// Fixed-point log2 of a nonzero distance: a serial leading-one search followed
// by one table lookup with linear interpolation.
// ----------------------------------------------------------------------------
module rahm_log2 import rahm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NORM_W-1:0] value_i,
  output logic              busy_o,
  output logic [LOG_W-1:0]  log_o
);

  logic [NORM_W-1:0]         x_q;
  logic [EXP_W-1:0]          e_q;
  logic                      busy_q;
  logic [LOG_W-1:0]          log_q;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [LOG_IDX_W-1:0]      idx_lo;
  logic [LOG_IDX_W-1:0]      idx_hi;
  logic [INTERP_BITS-1:0]    rem;
  logic [LOG_ENTRY_W-1:0]    t0;
  logic [LOG_ENTRY_W-1:0]    t1;
  logic [LOG_ENTRY_W-1:0]    step;
  logic [LOG_ENTRY_W+INTERP_BITS-1:0] interp;
  logic [LOG_FRAC_BITS-1:0]  frac;

  // Once the leading one sits at the top, the bits below it index the table
  // and the following bits interpolate between neighboring entries.
  always_comb begin
    idx    = x_q[NORM_W-2 -: LOG_TABLE_BITS];
    rem    = x_q[NORM_W-2-LOG_TABLE_BITS -: INTERP_BITS];
    idx_lo = {1'b0, idx};
    idx_hi = idx_lo + LOG_IDX_W'(1);
    t0     = LOG_ROM[idx_lo];
    t1     = LOG_ROM[idx_hi];
    step   = t1 - t0;
    interp = (LOG_ENTRY_W+INTERP_BITS)'(step) * (LOG_ENTRY_W+INTERP_BITS)'(rem);
    frac   = LOG_FRAC_BITS'(t0 + LOG_ENTRY_W'(interp >> INTERP_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && x_q[NORM_W-1]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= value_i;
      e_q <= EXP_W'(NORM_W - 1);
    end else if (busy_q) begin
      if (x_q[NORM_W-1]) begin
        log_q <= {e_q, frac};
      end else begin
        x_q <= {x_q[NORM_W-2:0], 1'b0};
        e_q <= e_q - EXP_W'(1);
      end
    end
  end

  assign busy_o = busy_q;
  assign log_o  = log_q;

endmodule

// ----- sv/rssi_anchor_health_monitor.sv -----
// ----------------------------------------------------------------------------
// rssi_anchor_health_monitor
// Health check of one anchor: log-distance residual, z-score and a saturating
// exponentially weighted average of z squared with warning and fault flags.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Word
//   -------  ---------  ------------------------  ---------------------------------
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o    rssi, ref rssi, exponent, dist, time
//   out      out        out_valid_o / out_stall_i  z_score, health_average, flags
//
// The time from acceptance of an input word to a loaded result grows with the
// larger leading-zero count (0 to 19) of the two 20-bit distances, since the
// leading-one search shifts one bit per cycle. Six products run one after
// another through one bit-serial multiplier.
// Reset is asynchronous and active low; it loads the register defaults and
// clears the average and the last seen time. No clearing pass follows.
// A result waits in the output register while the output is stalled; the
// block takes the next word meanwhile and holds its own result until the
// output register frees up.
// ----------------------------------------------------------------------------
module rssi_anchor_health_monitor import rahm_pkg::*; #(
  parameter int unsigned DIST_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Measurement words.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [11:0]    measured_rssi_i,
  input  logic signed [11:0]    ref_rssi_i,
  input  logic [10:0]           path_exponent_i,
  input  logic [19:0]           distance_mm_i,
  input  logic [31:0]           now_time_i,
  // Result words.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    z_score_o,
  output logic [23:0]           health_average_o,
  output logic                  warning_flag_o,
  output logic                  faulty_flag_o
);

  // Distance bits above DIST_BITS are ignored; the port holds at most 20.
  localparam int unsigned DistW = (DIST_BITS < NORM_W) ? DIST_BITS : NORM_W;

  rahm_state_e state_q, state_d;

  // Configuration registers.
  logic [16:0] lambda_q;
  logic [19:0] ref_dist_q;
  logic [15:0] inv_sigma_q;

  // Anchor state.
  logic [23:0] health_avg_q;
  logic [31:0] last_seen_q;

  // Captured word and intermediate results.
  logic signed [11:0] meas_q;
  logic signed [11:0] refr_q;
  logic [10:0]        n_q;
  logic               lneg_q;
  logic [21:0]        loss_q;
  logic               rneg_q;
  logic signed [15:0] z_q;
  logic [46:0]        lq_q;

  // Output register.
  logic               out_valid_q;
  logic signed [15:0] out_z_q;
  logic [23:0]        out_avg_q;
  logic               out_warn_q;
  logic               out_fault_q;

  logic              in_accept;
  logic              out_free;
  logic              out_load;
  logic              log_start;
  logic [NORM_W-1:0] dist_in;
  logic [NORM_W-1:0] dist_clamp;
  logic [NORM_W-1:0] d0_clamp;
  logic              log_d_busy;
  logic              log_0_busy;
  logic [LOG_W-1:0]  log_d;
  logic [LOG_W-1:0]  log_0;

  mul_req_t          mul_req;
  logic              mul_done;
  logic [MUL_PW-1:0] product;

  // Arithmetic between the multiplier passes.
  logic [LOG_W:0]      lg;
  logic                lneg;
  logic [LOG_W-1:0]    lmag;
  logic [MUL_PW-1:0]   loss_sum;
  logic [21:0]         loss;
  logic signed [12:0]  diff;
  logic [23:0]         loss_signed;
  logic [23:0]         resid;
  logic                rneg;
  logic [23:0]         rmag;
  logic [MUL_PW-1:0]   z_round;
  logic [18:0]         zmag;
  logic signed [15:0]  zsat;
  logic [15:0]         zabs;
  logic [16:0]         lam_sat;
  logic [16:0]         lam_inv;
  logic [48:0]         avg_sum;
  logic [24:0]         avg_raw;
  logic [23:0]         avg_sat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A zero distance, measured or reference, counts as one millimetre.
  always_comb begin
    dist_in    = NORM_W'(distance_mm_i[DistW-1:0]);
    dist_clamp = (dist_in == '0) ? NORM_W'(1) : dist_in;
    d0_clamp   = (ref_dist_q == '0) ? NORM_W'(1) : ref_dist_q;
  end

  rahm_log2 u_log_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (dist_clamp),
    .busy_o  (log_d_busy),
    .log_o   (log_d)
  );

  rahm_log2 u_log_ref (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (d0_clamp),
    .busy_o  (log_0_busy),
    .log_o   (log_0)
  );

  rahm_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .done_o    (mul_done),
    .product_o (product)
  );

  always_comb begin
    // The log ratio is handled as sign and magnitude through the products.
    lg   = {1'b0, log_d} - {1'b0, log_0};
    lneg = lg[LOG_W];
    lmag = lneg ? LOG_W'(-lg) : lg[LOG_W-1:0];

    // n * |L| * K back to Q.12 dB, nearest with ties away from zero.
    loss_sum = product + (MUL_PW'(1) << 27);
    loss     = loss_sum[49:28];

    // Residual in Q.12 dB: (measured - reference) plus the path loss.
    diff        = {meas_q[11], meas_q} - {refr_q[11], refr_q};
    loss_signed = lneg_q ? -{2'b00, loss_q} : {2'b00, loss_q};
    resid       = {{3{diff[12]}}, diff, 8'h00} + loss_signed;
    rneg        = resid[23];
    rmag        = rneg ? -resid : resid;

    // z from Q.28 to Q.8 on the magnitude, then saturated to 16 bits.
    z_round = product + (MUL_PW'(1) << 19);
    zmag    = z_round[38:20];
    if (!rneg_q) begin
      zsat = (zmag > 19'd32767) ? 16'sh7FFF : signed'(zmag[15:0]);
    end else begin
      zsat = (zmag > 19'd32768) ? 16'sh8000 : signed'(-zmag[15:0]);
    end
    zabs = z_q[15] ? unsigned'(-z_q) : unsigned'(z_q);

    // A weight above one acts as one.
    lam_sat = (lambda_q > LAMBDA_ONE) ? LAMBDA_ONE : lambda_q;
    lam_inv = LAMBDA_ONE - lam_sat;

    // Blend of the two products, rounded from Q.32 to Q.8 and saturated.
    avg_sum = 49'(lq_q) + {1'b0, product[39:0], 8'h00} + (49'(1) << 23);
    avg_raw = avg_sum[48:24];
    avg_sat = avg_raw[24] ? AVG_MAX : avg_raw[23:0];
  end

  // Sequencer: next state, log starts, multiplier requests and output load.
  always_comb begin
    state_d   = state_q;
    mul_req   = '0;
    log_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          log_start = 1'b1;
          state_d   = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!log_d_busy && !log_0_busy) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(lmag);
        mul_req.b     = MUL_BW'(n_q);
        state_d       = ST_MUL_NL;
      end
      ST_MUL_NL: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = product[MUL_AW-1:0];
          mul_req.b     = TEN_LOG10_2_Q16;
          state_d       = ST_MUL_K;
        end
      end
      ST_MUL_K: begin
        if (mul_done) begin
          state_d = ST_RESID;
        end
      end
      ST_RESID: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(rmag);
        mul_req.b     = MUL_BW'(inv_sigma_q);
        state_d       = ST_MUL_SIG;
      end
      ST_MUL_SIG: begin
        if (mul_done) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_AW'(zabs);
        mul_req.b     = MUL_BW'(zabs);
        state_d       = ST_MUL_ZZ;
      end
      ST_MUL_ZZ: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(product[30:0]);
          mul_req.b     = MUL_BW'(lam_sat);
          state_d       = ST_MUL_LQ;
        end
      end
      ST_MUL_LQ: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(health_avg_q);
          mul_req.b     = MUL_BW'(lam_inv);
          state_d       = ST_MUL_LA;
        end
      end
      ST_MUL_LA: begin
        if (mul_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lambda_q     <= 17'd6554;
      ref_dist_q   <= 20'd1000;
      inv_sigma_q  <= 16'd16384;
      health_avg_q <= '0;
      last_seen_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // Writes to an index past the register list are dropped.
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_LAMBDA:    lambda_q    <= cfg_data_i[16:0];
          CFG_REF_DIST:  ref_dist_q  <= cfg_data_i[19:0];
          CFG_INV_SIGMA: inv_sigma_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        last_seen_q <= now_time_i;
      end
      if (state_q == ST_MUL_LA && mul_done) begin
        health_avg_q <= avg_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      meas_q <= measured_rssi_i;
      refr_q <= ref_rssi_i;
      n_q    <= path_exponent_i;
    end
    if (state_q == ST_PREP) begin
      lneg_q <= lneg;
    end
    if (state_q == ST_MUL_K && mul_done) begin
      loss_q <= loss;
    end
    if (state_q == ST_RESID) begin
      rneg_q <= rneg;
    end
    if (state_q == ST_MUL_SIG && mul_done) begin
      z_q <= zsat;
    end
    if (state_q == ST_MUL_LQ && mul_done) begin
      lq_q <= product[46:0];
    end
    if (out_load) begin
      out_z_q     <= z_q;
      out_avg_q   <= health_avg_q;
      out_warn_q  <= (health_avg_q >= WARN_LEVEL) && (health_avg_q < FAULT_LEVEL);
      out_fault_q <= (health_avg_q >= FAULT_LEVEL);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign z_score_o        = out_z_q;
  assign health_average_o = out_avg_q;
  assign warning_flag_o   = out_warn_q;
  assign faulty_flag_o    = out_fault_q;

endmodule

// ----- sv/rahm_checker.sv -----
// ----------------------------------------------------------------------------
// rahm_checker
// Port-level checks of the anchor health monitor, bound to the top level.
// ----------------------------------------------------------------------------
module rahm_checker import rahm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] z_score_o,
  input logic [23:0]        health_average_o,
  input logic               warning_flag_o,
  input logic               faulty_flag_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(z_score_o) && $stable(health_average_o))
    else $error("stalled result word changed");

  // The flags follow the reported average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (faulty_flag_o == (health_average_o >= FAULT_LEVEL)) &&
                    (warning_flag_o == ((health_average_o >= WARN_LEVEL) &&
                                        (health_average_o < FAULT_LEVEL))))
    else $error("flags disagree with the average");

  // One word is worked at a time: after acceptance the input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in progress");

endmodule

bind rssi_anchor_health_monitor rahm_checker u_rahm_checker (.*);
